### src/rgba_alu_pkg.sv
// Shared types and constants for the RGBA8 saturating colour ALU.
package rgba_alu_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam int IN_DATA_W      = 104;
  localparam int OUT_DATA_W     = 32;
  localparam logic [7:0] CHAN_MAX = 8'd255;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_ADDS     = 4'd4,
    OP_SUBS     = 4'd5,
    OP_INV      = 4'd6,
    OP_INV_RGB  = 4'd7,
    OP_LERP     = 4'd8,
    OP_LERP_RGB = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_FIXED  = 2'd1,
    MODE_DIV    = 2'd2
  } mode_t;

  // Classified request handed from front to back.
  typedef struct packed {
    mode_t [3:0]      mode;
    logic [3:0][7:0]  dval;
    logic [3:0][7:0]  a;
    logic [3:0][8:0]  m;
    logic [3:0]       base;
    logic [32:0]      s33;
    logic             dz;
  } item_t;

  typedef struct packed {
    logic [3:0][7:0] color;
    logic            dz;
  } res_t;

endpackage

### src/rgba_alu_front.sv
// Front end: accepts requests, decodes the opcode and classifies each channel.
module rgba_alu_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rgba_alu_pkg::IN_DATA_W-1:0]  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rgba_alu_pkg::item_t                 out_item
);

  logic                 fv_r;
  rgba_alu_pkg::item_t  fi_r;
  rgba_alu_pkg::item_t  fi_nxt;
  rgba_alu_pkg::op_t    op;
  logic [3:0][7:0]      a;
  logic [3:0][7:0]      b;
  logic [31:0]          s;
  logic [32:0]          s_ext;
  logic [8:0]           sum9;

  assign op    = rgba_alu_pkg::op_t'(in_data[3:0]);
  assign s     = in_data[99:68];
  assign s_ext = {s[31], s};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a[k] = in_data[4 + 8*k +: 8];
      b[k] = in_data[36 + 8*k +: 8];
    end
  end

  always_comb begin
    fi_nxt     = '0;
    fi_nxt.a   = a;
    fi_nxt.s33 = s_ext;
    fi_nxt.dz  = (op == rgba_alu_pkg::OP_DIV) && (s == 32'd0);
    sum9       = '0;
    for (int k = 0; k < 4; k++) begin
      fi_nxt.mode[k] = rgba_alu_pkg::MODE_DIRECT;
      fi_nxt.dval[k] = a[k];
      case (op)
        rgba_alu_pkg::OP_ADD: begin
          sum9 = {1'b0, a[k]} + {1'b0, b[k]};
          fi_nxt.dval[k] = sum9[8] ? rgba_alu_pkg::CHAN_MAX : sum9[7:0];
        end
        rgba_alu_pkg::OP_SUB: begin
          fi_nxt.dval[k] = (a[k] >= b[k]) ? (a[k] - b[k]) : 8'd0;
        end
        rgba_alu_pkg::OP_MUL: begin
          fi_nxt.mode[k] = rgba_alu_pkg::MODE_FIXED;
          fi_nxt.m[k]    = {1'b0, a[k]};
        end
        rgba_alu_pkg::OP_DIV: begin
          if (!s[31] && (s != 32'd0)) begin
            fi_nxt.mode[k] = rgba_alu_pkg::MODE_DIV;
          end else begin
            fi_nxt.dval[k] = 8'd0;
          end
        end
        rgba_alu_pkg::OP_ADDS, rgba_alu_pkg::OP_SUBS: begin
          fi_nxt.mode[k] = rgba_alu_pkg::MODE_FIXED;
          fi_nxt.m[k]    = 9'd1;
          fi_nxt.base[k] = 1'b1;
        end
        rgba_alu_pkg::OP_INV: begin
          fi_nxt.dval[k] = rgba_alu_pkg::CHAN_MAX - a[k];
        end
        rgba_alu_pkg::OP_INV_RGB: begin
          if (k != 3) fi_nxt.dval[k] = rgba_alu_pkg::CHAN_MAX - a[k];
        end
        rgba_alu_pkg::OP_LERP, rgba_alu_pkg::OP_LERP_RGB: begin
          if (k != 3 || op == rgba_alu_pkg::OP_LERP) begin
            fi_nxt.mode[k] = rgba_alu_pkg::MODE_FIXED;
            fi_nxt.m[k]    = {1'b0, b[k]} - {1'b0, a[k]};
            fi_nxt.base[k] = 1'b1;
          end
        end
        default: begin
          fi_nxt.dval[k] = a[k];
        end
      endcase
    end
    if (op == rgba_alu_pkg::OP_SUBS) fi_nxt.s33 = -s_ext;
  end

  assign in_ready  = !fv_r || out_ready;
  assign out_valid = fv_r;
  assign out_item  = fi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fi_r <= fi_nxt;
    end
  end

endmodule

### src/rgba_alu_fifo.sv
// Short request queue between the front end and the back end.
module rgba_alu_fifo #(
  parameter int DEPTH = rgba_alu_pkg::FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  rgba_alu_pkg::item_t  wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output rgba_alu_pkg::item_t  rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rgba_alu_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          push, pop;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule

### src/rgba_alu_back.sv
// Back end: multiply, fixed-point conversion and pipelined restoring divide.
module rgba_alu_back #(
  parameter int FRAC_BITS = rgba_alu_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rgba_alu_pkg::item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rgba_alu_pkg::res_t   out_res
);

  localparam int NST = 10;
  localparam int WN  = 8 + FRAC_BITS;
  localparam int WC  = (WN > 39) ? WN + 1 : 40;
  localparam int WP  = 42;
  localparam int WV  = 43;

  typedef struct packed {
    rgba_alu_pkg::mode_t [3:0] mode;
    logic [3:0][7:0]           dval;
    logic [3:0][7:0]           a;
    logic [3:0]                base;
    logic [3:0][WV-1:0]        p;
    logic [3:0]                ovf;
    logic [3:0][WN-1:0]        rem;
    logic [3:0][7:0]           q;
    logic [3:0][7:0]           fx;
    logic [30:0]               dvs;
    logic                      dz;
  } stage_t;

  stage_t           st_r   [NST];
  stage_t           st_nxt [NST];
  logic [NST-1:0]   vld_r;
  logic             adv;

  logic signed [8:0]    m_s    [4];
  logic signed [32:0]   s_s;
  logic signed [WP-1:0] prod   [4];
  logic signed [WV-1:0] v      [4];
  logic        [WV-1:0] sh     [4];
  logic        [WC-1:0] trial  [NST][4];

  assign adv      = !vld_r[NST-1] || out_ready;
  assign in_ready = adv;
  assign s_s      = $signed(in_item.s33);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      m_s[c]  = $signed(in_item.m[c]);
      prod[c] = WP'(m_s[c]) * WP'(s_s);
    end
  end

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      for (int c = 0; c < 4; c++) trial[k][c] = '0;
      if (k == 0) begin
        st_nxt[k]      = '0;
        st_nxt[k].mode = in_item.mode;
        st_nxt[k].dval = in_item.dval;
        st_nxt[k].a    = in_item.a;
        st_nxt[k].base = in_item.base;
        st_nxt[k].dvs  = in_item.s33[30:0];
        st_nxt[k].dz   = in_item.dz;
        for (int c = 0; c < 4; c++) begin
          st_nxt[k].p[c]   = WV'(prod[c]);
          st_nxt[k].rem[c] = {in_item.a[c], {FRAC_BITS{1'b0}}};
          st_nxt[k].ovf[c] = (WC'(st_nxt[k].rem[c]) >= (WC'(in_item.s33[30:0]) << 8));
        end
      end else begin
        st_nxt[k] = st_r[k-1];
        for (int c = 0; c < 4; c++) begin
          if (k == 1 && st_r[k-1].base[c]) begin
            st_nxt[k].p[c] = st_r[k-1].p[c] + WV'({st_r[k-1].a[c], {FRAC_BITS{1'b0}}});
          end
          if (k >= 1 && k <= 8) begin
            trial[k][c] = WC'(st_r[k-1].dvs) << (8 - k);
            if (WC'(st_r[k-1].rem[c]) >= trial[k][c]) begin
              st_nxt[k].rem[c]           = st_r[k-1].rem[c] - WN'(trial[k][c]);
              st_nxt[k].q[c][3'(8 - k)] = 1'b1;
            end
          end
          if (k == NST - 1) begin
            case (st_r[k-1].mode[c])
              rgba_alu_pkg::MODE_FIXED: st_nxt[k].fx[c] = st_r[k-1].fx[c];
              rgba_alu_pkg::MODE_DIV:
                st_nxt[k].fx[c] = st_r[k-1].ovf[c] ? rgba_alu_pkg::CHAN_MAX : st_r[k-1].q[c];
              default: st_nxt[k].fx[c] = st_r[k-1].dval[c];
            endcase
          end
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      v[c]  = $signed(st_r[1].p[c]);
      sh[c] = WV'(v[c] >>> FRAC_BITS);
      if (v[c] < 0)            st_nxt[2].fx[c] = 8'd0;
      else if (|sh[c][WV-1:8]) st_nxt[2].fx[c] = rgba_alu_pkg::CHAN_MAX;
      else                     st_nxt[2].fx[c] = sh[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) st_r[k] <= st_nxt[k];
    end
  end

  assign out_valid     = vld_r[NST-1];
  assign out_res.color = st_r[NST-1].fx;
  assign out_res.dz    = st_r[NST-1].dz;

endmodule

### src/rgba8_saturating_colour_alu_unit.sv
// Top level of the RGBA8 saturating colour ALU.
//
// Input stream (in_*): one request per beat, accepted when in_tvalid and
// in_tready are both high. It carries an opcode, colours A and B and a
// signed fixed-point scalar with FRAC_BITS fraction bits.
// Output stream (out_*): one result per request, in order; out_tuser flags
// a divide by zero, in which case all four channels read zero.
// Path from acceptance to out_tvalid: one decode register, the request
// queue and a ten-stage back end whose depth is set by the eight
// quotient-bit stages of the divider. Throughput is one request per
// cycle while out_tready stays high. With out_tready low and a result
// waiting, the back end holds; the queue keeps taking decoded requests
// until it fills, and in_tready drops only then.
// Synchronous reset (rst_n low) empties every stage and the queue; the
// data registers themselves are not reset.
module rgba8_saturating_colour_alu_unit #(
  parameter int FRAC_BITS  = rgba_alu_pkg::FRAC_BITS_DEF,
  parameter int FIFO_DEPTH = rgba_alu_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // opcode, a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue,
  // b_alpha, scalar (low to high), zero fill to 104
  input  logic [rgba_alu_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_red, out_green, out_blue, out_alpha (low to high)
  output logic [rgba_alu_pkg::OUT_DATA_W-1:0]  out_tdata,
  // divide_by_zero
  output logic                                 out_tuser
);

  logic                f_valid, f_ready;
  rgba_alu_pkg::item_t f_item;
  logic                q_valid, q_ready;
  rgba_alu_pkg::item_t q_item;
  rgba_alu_pkg::res_t  res;

  rgba_alu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  rgba_alu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  rgba_alu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = res.color;
  assign out_tuser = res.dz;

endmodule

### src/rgba_alu_chk.sv
// Port-level checker for the RGBA8 saturating colour ALU, with its bind.
module rgba_alu_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [rgba_alu_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [rgba_alu_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                                out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("divide by zero with nonzero channels");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

endmodule

bind rgba8_saturating_colour_alu_unit rgba_alu_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
